FILE: design/sorted_table_binary_search_top_assert.svh
// Assertion macros for the sorted table search block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define STBS_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define STBS_CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define STBS_CHECK(label, prop, msg)
`define STBS_CHECK_IMPL(label, ante, cons, msg)
`endif

`endif

FILE: design/stbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int INDEX_W    = 10;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 11;

    typedef logic [1:0] action_t;

    localparam action_t ACT_WRITE = 2'd0;
    localparam action_t ACT_LOWER = 2'd1;
    localparam action_t ACT_UPPER = 2'd2;
    localparam action_t ACT_EXACT = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_TABLE_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DESCENDING  = 1'd1;

    typedef struct packed {
        action_t                   action;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [DATA_W-1:0]  entry_value;
        logic signed [DATA_W-1:0]  search_key;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } out_item_t;

endpackage

`default_nettype wire

FILE: design/stbs_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-port-write, registered-read table storage.
module stbs_table
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
)(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/sorted_table_binary_search_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Beat
// -------  ---------------------  ----------------------------------------
// in       in_valid / in_ready    in_item_t: write entry or query
// out      out_valid / out_ready  out_item_t: position and found flag
// cfg      cfg_valid / cfg_ready  cfg_addr (0 table_count, 1 descending)
//
// Write beat: no result. Query beat: one result, over n = min(table_count, TABLE_DEPTH) entries.
// One halving step per cycle, paced by the table's registered read port.
// in_ready is low while a query runs and returns the cycle after its result is
// loaded; a stalled result only holds the final step. cfg_ready is always high.
// Reset clears control and config (table_count 1, ascending); entries undefined.

`include "sorted_table_binary_search_top_assert.svh"

module sorted_table_binary_search_top
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Sequencer: idle, or one halving step per cycle
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_STEP = 1'b1;

    logic                    state_reg, state_next;
    logic [POS_W-1:0]        cfg_count_reg, cfg_count_next;
    logic                    cfg_desc_reg, cfg_desc_next;
    logic                    out_valid_reg, out_valid_next;

    // Search datapath (no reset needed)
    logic [POS_W-1:0]        lo_reg, lo_next;
    logic [POS_W-1:0]        n_reg, n_next;
    logic [POS_W-1:0]        cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0]  key_reg, key_next;
    logic                    upper_reg, upper_next;
    logic                    desc_reg, desc_next;
    logic                    exact_reg, exact_next;
    out_item_t               out_data_reg, out_data_next;

    logic                    in_acc;
    logic                    out_free;
    logic [POS_W-1:0]        n0;
    logic [POS_W-1:0]        half;
    logic [POS_W-1:0]        mid;
    logic [POS_W-1:0]        lo_step;
    logic [POS_W-1:0]        n_step;
    logic                    precedes;
    logic                    hit;
    logic [POS_W-1:0]        rd_pos;
    logic [POS_W+AW-1:0]     rd_wide;
    logic [INDEX_W+AW-1:0]   wr_wide;
    logic [DATA_W+VALUE_WIDTH-1:0] val_wide;
    logic [DATA_W+VALUE_WIDTH-1:0] key_wide;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [VALUE_WIDTH-1:0]  wr_data;
    logic [AW-1:0]           rd_addr;
    logic [VALUE_WIDTH-1:0]  rd_data;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Fields keep their low VALUE_WIDTH bits, zero-filled above 32
    assign val_wide = {{VALUE_WIDTH{1'b0}}, in_data.entry_value};
    assign key_wide = {{VALUE_WIDTH{1'b0}}, in_data.search_key};
    assign wr_wide  = {{AW{1'b0}}, in_data.entry_index};

    assign wr_en   = in_acc && (in_data.action == ACT_WRITE) &&
                     (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
    assign wr_addr = wr_wide[AW-1:0];
    assign wr_data = val_wide[VALUE_WIDTH-1:0];

    // Searched length saturates at the table depth
    assign n0 = (32'(cfg_count_reg) > 32'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                        : cfg_count_reg;

    // One halving step against the entry read last cycle at mid
    assign half = n_reg >> 1;
    assign mid  = lo_reg + half;

    always_comb
    begin
        if (desc_reg)
        begin
            precedes = upper_reg ? ($signed(rd_data) >= $signed(key_reg))
                                 : ($signed(rd_data) >  $signed(key_reg));
        end
        else
        begin
            precedes = upper_reg ? ($signed(rd_data) <= $signed(key_reg))
                                 : ($signed(rd_data) <  $signed(key_reg));
        end
    end

    assign lo_step = precedes ? (mid + POS_W'(1)) : lo_reg;
    assign n_step  = precedes ? (n_reg - half - POS_W'(1)) : half;

    // Window closed: rd_data holds the entry at lo
    assign hit = (lo_reg < cnt_reg) && (rd_data == key_reg);

    // Read address: next mid, or lo itself once the window is empty
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_pos = n0 >> 1;
        end
        else if (n_reg == '0)
        begin
            rd_pos = lo_reg;
        end
        else
        begin
            rd_pos = lo_step + (n_step >> 1);
        end
    end

    assign rd_wide = {{AW{1'b0}}, rd_pos};
    assign rd_addr = rd_wide[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cfg_count_next = cfg_count_reg;
        cfg_desc_next  = cfg_desc_reg;
        out_valid_next = out_valid_reg;
        lo_next        = lo_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        upper_next     = upper_reg;
        desc_next      = desc_reg;
        exact_next     = exact_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_TABLE_COUNT: cfg_count_next = cfg_data;
                REG_DESCENDING:  cfg_desc_next  = cfg_data[0];
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                lo_next  = '0;
                n_next   = n0;
                cnt_next = n0;
                key_next = key_wide[VALUE_WIDTH-1:0];
                case (in_data.action)
                    ACT_LOWER:
                    begin
                        upper_next = 1'b0;
                        desc_next  = cfg_desc_reg;
                        exact_next = 1'b0;
                    end
                    ACT_UPPER:
                    begin
                        upper_next = 1'b1;
                        desc_next  = cfg_desc_reg;
                        exact_next = 1'b0;
                    end
                    default:
                    begin
                        // exact match: always ascending lower bound
                        upper_next = 1'b0;
                        desc_next  = 1'b0;
                        exact_next = 1'b1;
                    end
                endcase
                if (in_acc && (in_data.action != ACT_WRITE))
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (n_reg != '0)
                begin
                    lo_next = lo_step;
                    n_next  = n_step;
                end
                else if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (exact_reg)
                    begin
                        out_data_next.position = hit ? lo_reg : '0;
                        out_data_next.found    = hit;
                    end
                    else
                    begin
                        out_data_next.position = lo_reg;
                        out_data_next.found    = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_count_reg <= POS_W'(1);
            cfg_desc_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_count_reg <= cfg_count_next;
            cfg_desc_reg  <= cfg_desc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        n_reg        <= n_next;
        cnt_reg      <= cnt_next;
        key_reg      <= key_next;
        upper_reg    <= upper_next;
        desc_reg     <= desc_next;
        exact_reg    <= exact_next;
        out_data_reg <= out_data_next;
    end

    stbs_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A result beat only appears as the search window closes
    `STBS_CHECK_IMPL(a_out_from_step, $rose(out_valid_reg), $past(state_reg) == ST_STEP, "result without search")
    // Search window stays inside the searched length
    `STBS_CHECK_IMPL(a_window, state_reg == ST_STEP, (lo_reg <= cnt_reg) && (n_reg <= cnt_reg - lo_reg), "window out of range")
    // A miss always reports position zero
    `STBS_CHECK(a_miss_pos, !(out_valid_reg && !out_data_reg.found) || (out_data_reg.position == '0), "miss with nonzero position")

endmodule

`default_nettype wire

FILE: verif/stbs_tb_pkg.sv
`timescale 1ns / 1ps

package stbs_tb_pkg;
    import stbs_pkg::*;

    class search_scoreboard;
        logic signed [DATA_W-1:0] entries [DEF_TABLE_DEPTH];
        logic [CFG_DATA_W-1:0]    count_reg;
        bit                       desc_reg;
        out_item_t                awaited_results [$];
        int                       errors;
        int                       checked;

        function new();
            foreach (entries[i])
                entries[i] = '0;
            count_reg = CFG_DATA_W'(1);
            desc_reg  = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("ERROR: %s", msg);
        endtask

        function void set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr == REG_TABLE_COUNT)
                count_reg = data;
            else if (addr == REG_DESCENDING)
                desc_reg = data[0];
        endfunction

        // entry sits strictly left of the answer
        function bit entry_precedes(logic signed [DATA_W-1:0] e, k, bit upper, bit desc);
            if (!desc)
                return upper ? (e <= k) : (e < k);
            return upper ? (e >= k) : (e > k);
        endfunction

        function int bisect(logic signed [DATA_W-1:0] key, int span_len, bit upper, bit desc);
            int lo;
            int n;
            int half;
            int mid;
            lo = 0;
            n  = span_len;
            while (n > 0)
            begin
                half = n / 2;
                mid  = lo + half;
                if (mid < DEF_TABLE_DEPTH && entry_precedes(entries[mid], key, upper, desc))
                begin
                    lo = mid + 1;
                    n  = n - half - 1;
                end
                else
                begin
                    n = half;
                end
            end
            return lo;
        endfunction

        function void note_beat(in_item_t beat);
            out_item_t want;
            int        live;
            int        pos;
            if (beat.action == ACT_WRITE)
            begin
                entries[beat.entry_index] = beat.entry_value;
                return;
            end
            live = (count_reg > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : int'(count_reg);
            if (beat.action == ACT_EXACT)
            begin
                pos = bisect(beat.search_key, live, 1'b0, 1'b0);
                if (pos < live && entries[pos] == beat.search_key)
                    want.found = 1'b1;
                else
                begin
                    pos        = 0;
                    want.found = 1'b0;
                end
            end
            else
            begin
                pos = bisect(beat.search_key, live, beat.action == ACT_UPPER, desc_reg);
                want.found = 1'b1;
            end
            want.position = POS_W'(pos);
            awaited_results.insert(awaited_results.size(), want);
        endfunction

        task check_beat(out_item_t got);
            out_item_t want;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("result pos=%0d found=%0b with no query outstanding",
                                 got.position, got.found));
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (got.position !== want.position)
                report($sformatf("position %0d, wanted %0d", got.position, want.position));
            if (got.found !== want.found)
                report($sformatf("found %0b, wanted %0b (pos %0d)",
                                 got.found, want.found, want.position));
        endtask
    endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Sorted table search: directed corner beats, a full 1024-entry load, then
// random phases of small prefixes, mostly sorted, with mixed lower/upper/exact queries.
module tb_top;
    import stbs_pkg::*;
    import stbs_tb_pkg::*;

    localparam int ITEM_GOAL     = 1600;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;     // longer than a full-table query
    localparam logic signed [DATA_W-1:0] KEY_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] KEY_MAX = ~KEY_MIN;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    search_scoreboard sb = new();

    // what the table is believed to hold; keys are drawn from it
    logic signed [DATA_W-1:0] load_vals [DEF_TABLE_DEPTH];

    int  beats_sent  = 0;
    int  action_tally [4];
    int  reg_writes  = 0;
    int  cycle_count = 0;
    int  hold_off    = 0;   // long receiver hold-off, counted down by the sink
    int  stall_left  = 0;
    bit  src_gaps    = 1'b1;
    bit  sink_stalls = 1'b1;

    sorted_table_binary_search_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Monitor: all three channels sampled at the rising edge, before any
    // flop in the block updates. Register writes first, then input, then output.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_addr, cfg_data);
            if (in_valid && in_ready)
                sb.note_beat(in_data);
            if (out_valid && out_ready)
                sb.check_beat(out_data);
        end
    end

    // Result sink. A requested hold-off wins over the random stall bursts.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready = 1'b0;
            hold_off  = hold_off - 1;
        end
        else if (stall_left > 0)
        begin
            out_ready  = 1'b0;
            stall_left = stall_left - 1;
        end
        else if (sink_stalls && $urandom_range(0, 15) == 0)
        begin
            out_ready  = 1'b0;
            stall_left = $urandom_range(0, 17);
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_table_binary_search_top: mismatch");
        $finish;
    end

    // Offer one beat; valid stays up until the handshake. A source gap, when
    // taken, drops valid before the beat rather than after it.
    task automatic push_beat(input in_item_t beat);
        @(negedge clk);
        if (src_gaps && $urandom_range(0, 9) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = beat;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        action_tally[beat.action]++;
    endtask

    task automatic push_write(input int idx, input logic signed [DATA_W-1:0] val);
        in_item_t beat;
        beat.action      = ACT_WRITE;
        beat.entry_index = INDEX_W'(idx);
        beat.entry_value = val;
        beat.search_key  = $urandom();   // don't-care on a write
        load_vals[idx]   = val;
        push_beat(beat);
    endtask

    task automatic push_query(input action_t act, input logic signed [DATA_W-1:0] key);
        in_item_t beat;
        beat.action      = act;
        beat.entry_index = INDEX_W'($urandom());   // don't-care on a query
        beat.entry_value = $urandom();
        beat.search_key  = key;
        push_beat(beat);
    endtask

    // Stop offering, let every query come back, then give trailing writes
    // time to land before touching registers.
    task automatic quiesce();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_addr  = addr;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        reg_writes++;
    endtask

    // only bit 0 matters; upper bits get junk
    task automatic set_order(input bit desc);
        logic [CFG_DATA_W-1:0] word;
        word    = CFG_DATA_W'($urandom());
        word[0] = desc;
        write_reg(REG_DESCENDING, word);
    endtask

    // Load entries [0, n) with a monotone run (duplicates, small and large
    // strides, clamped at the top), mirrored when desc; or plain noise.
    task automatic load_prefix(input int n, input bit desc, input bit scrambled);
        logic signed [DATA_W-1:0] vals [DEF_TABLE_DEPTH];
        longint span;
        longint v;
        span = 64'sd4294967296 / (n + 1);
        if ($urandom_range(0, 3) == 0)
            v = longint'(KEY_MIN);
        else
            v = longint'(KEY_MIN) + longint'($urandom_range(0, 32'h8000_0000));
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: v = v;
                1: v = v + $urandom_range(1, 3);
                2: v = v + longint'($urandom_range(1, span));
                default: v = v + span + longint'($urandom_range(0, span));
            endcase
            if (v > longint'(KEY_MAX))
                v = longint'(KEY_MAX);
            vals[desc ? n - 1 - i : i] = scrambled ? DATA_W'($urandom()) : v[DATA_W-1:0];
        end
        for (int i = 0; i < n; i++)
            push_write(i, vals[i]);
    endtask

    // Keys: exact table hits, off-by-one neighbors, extremes, noise.
    function automatic logic signed [DATA_W-1:0] pick_key(input int live);
        int i;
        i = (live > 0) ? $urandom_range(0, live - 1) : 0;
        case ($urandom_range(0, 5))
            0, 1:    return load_vals[i];
            2:       return load_vals[i] - 1;
            3:       return load_vals[i] + 1;
            4:       return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
            default: return $urandom();
        endcase
    endfunction

    // Mostly queries; now and then an entry is overwritten with its left
    // neighbor's value, which keeps a sorted prefix sorted.
    task automatic run_queries(input int n, input int cnt);
        int live;
        int i;
        live = (n > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : n;
        repeat (cnt)
        begin
            if (live > 1 && $urandom_range(0, 9) == 0)
            begin
                i = $urandom_range(1, live - 1);
                push_write(i, load_vals[i - 1]);
            end
            else
            begin
                push_query(action_t'($urandom_range(ACT_LOWER, ACT_EXACT)), pick_key(live));
            end
        end
    endtask

    initial
    begin : stimulus
        int n;
        bit desc;

        foreach (load_vals[i])
            load_vals[i] = '0;
        foreach (action_tally[i])
            action_tally[i] = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed: reset config is one entry, ascending ---
        push_write(0, KEY_MIN);
        push_query(ACT_LOWER, KEY_MIN);
        push_query(ACT_UPPER, KEY_MIN);          // past the only entry
        push_query(ACT_EXACT, KEY_MIN);
        push_query(ACT_EXACT, '0);               // miss: position forced to 0
        push_query(ACT_LOWER, KEY_MAX);
        push_write(1, -1);
        push_write(2, 0);
        push_write(3, KEY_MAX);
        push_write(DEF_TABLE_DEPTH - 1, KEY_MAX);

        // empty range: bounds give 0/found, exact gives 0/not found
        quiesce();
        write_reg(REG_TABLE_COUNT, CFG_DATA_W'(0));
        push_query(ACT_LOWER, '0);
        push_query(ACT_UPPER, '0);
        push_query(ACT_EXACT, KEY_MIN);

        quiesce();
        write_reg(REG_TABLE_COUNT, CFG_DATA_W'(4));
        push_query(ACT_LOWER, -1);
        push_query(ACT_UPPER, -1);
        push_query(ACT_EXACT, KEY_MAX);
        push_query(ACT_EXACT, 5);
        push_query(ACT_UPPER, KEY_MAX);          // answer equals the count

        // descending table with duplicates; exact still searches ascending
        quiesce();
        set_order(1'b1);
        push_write(0, KEY_MAX);
        push_write(1, 0);
        push_write(2, 0);
        push_write(3, KEY_MIN);
        push_query(ACT_LOWER, '0);
        push_query(ACT_UPPER, '0);
        push_query(ACT_EXACT, '0);

        // --- full table: every index written, so any count is legal after this ---
        quiesce();
        write_reg(REG_TABLE_COUNT, CFG_DATA_W'(DEF_TABLE_DEPTH));
        set_order(1'b0);
        load_prefix(DEF_TABLE_DEPTH, 1'b0, 1'b0);
        // sink holds off while the source keeps pushing: the block backs up
        hold_off = 260;
        run_queries(DEF_TABLE_DEPTH, 70);

        // count above the depth saturates; order flag flipped on an ascending table
        quiesce();
        write_reg(REG_TABLE_COUNT, {CFG_DATA_W{1'b1}});
        set_order(1'b1);
        run_queries(DEF_TABLE_DEPTH, 30);

        // --- random phases ---
        while (beats_sent < ITEM_GOAL)
        begin
            quiesce();
            case ($urandom_range(0, 9))
                0:       n = 0;
                1:       n = 1;
                2:       n = $urandom_range(DEF_TABLE_DEPTH, (1 << CFG_DATA_W) - 1);
                default: n = $urandom_range(2, 40);
            endcase
            desc = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_TABLE_COUNT, CFG_DATA_W'(n));
                set_order(desc);
            end
            else
            begin
                set_order(desc);
                write_reg(REG_TABLE_COUNT, CFG_DATA_W'(n));
            end
            if (beats_sent > ITEM_GOAL - 250)
            begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end
            else
            begin
                src_gaps    = ($urandom_range(0, 2) != 0);
                sink_stalls = ($urandom_range(0, 2) != 0);
            end
            if (n > 0 && n <= 40)
                load_prefix(n, desc, $urandom_range(0, 7) == 0);
            run_queries(n, 12 + $urandom_range(0, 2 * ((n > 40) ? 40 : n)));
        end

        quiesce();
        $display("Covered %0d writes, %0d lower / %0d upper / %0d exact queries, %0d reg writes.",
                 action_tally[ACT_WRITE], action_tally[ACT_LOWER],
                 action_tally[ACT_UPPER], action_tally[ACT_EXACT], reg_writes);
        $display("Checked %0d results in %0d cycles, %0d discrepancies.",
                 sb.checked, cycle_count, sb.errors);
        if (sb.errors == 0)
            $display("sorted_table_binary_search_top: match");
        else
            $display("sorted_table_binary_search_top: mismatch");
        $finish;
    end

endmodule
